// ----- design/gcbb_pkg.sv -----
// Shared types and constants for the glyph cell bounding box block.
package gcbb_pkg;

    // APB address width: two 32-bit registers at byte offsets 0 and 4
    localparam int CFG_AW = 3;

    // Cell size after reset, in pixels
    localparam logic [4:0] CFG_SIZE_RESET = 5'd8;

    // Register select, taken from paddr[2]
    typedef enum logic [0:0] {
        REG_CELL_WIDTH  = 1'b0,
        REG_CELL_HEIGHT = 1'b1
    } t_cfg_reg;

    // Empty space glyph gets a fixed pen advance
    localparam logic [31:0] SPACE_CODE    = 32'd32;
    localparam logic [4:0]  SPACE_ADVANCE = 5'd4;

    // One finished glyph descriptor
    typedef struct packed {
        logic [7:0] glyph_index;
        logic       is_empty;
        logic [3:0] bearing_x;
        logic [3:0] bearing_y;
        logic [4:0] glyph_width;
        logic [4:0] glyph_height;
        logic [4:0] advance;
    } t_glyph_result;

endpackage

// ----- design/gcbb_result.sv -----
// Glyph descriptor formatting from a finished cell's bounding box.
module gcbb_result import gcbb_pkg::*; #(
    parameter int CW = 5,
    parameter int IW = 8
) (
    input  logic [CW-1:0]  i_cell_w,
    input  logic [CW-1:0]  i_cell_h,
    input  logic [CW-1:0]  i_min_x,
    input  logic [CW-1:0]  i_min_y,
    input  logic [CW-1:0]  i_max_x,
    input  logic [CW-1:0]  i_max_y,
    input  logic           i_box_valid,
    input  logic [IW-1:0]  i_index,
    output t_glyph_result  o_result
);

    // Extended width keeps every intermediate free of overflow before masking
    localparam int EW = CW + 4;

    logic [EW-1:0] w_ext;
    logic [EW-1:0] bear_y;
    logic [EW-1:0] box_w;
    logic [EW-1:0] box_h;
    logic [EW-1:0] adv_raw;
    logic [EW-1:0] adv;
    logic [31:0]   idx_ext;

    assign w_ext   = EW'(i_cell_w);
    assign bear_y  = EW'(i_cell_h) - EW'(1) - EW'(i_min_y);
    assign box_w   = EW'(i_max_x) - EW'(i_min_x) + EW'(1);
    assign box_h   = EW'(i_max_y) - EW'(i_min_y) + EW'(1);
    assign adv_raw = EW'(i_max_x) + EW'(2);
    assign adv     = (adv_raw > w_ext) ? w_ext : adv_raw;
    assign idx_ext = 32'(i_index);

    // Build the descriptor, empty cells report a zero box
    always_comb begin
        o_result.glyph_index = idx_ext[7:0];
        if (!i_box_valid) begin
            o_result.is_empty     = 1'b1;
            o_result.bearing_x    = '0;
            o_result.bearing_y    = '0;
            o_result.glyph_width  = '0;
            o_result.glyph_height = '0;
            o_result.advance      = (idx_ext == SPACE_CODE) ? SPACE_ADVANCE : '0;
        end else begin
            o_result.is_empty     = 1'b0;
            o_result.bearing_x    = 4'(EW'(i_min_x));
            o_result.bearing_y    = bear_y[3:0];
            o_result.glyph_width  = box_w[4:0];
            o_result.glyph_height = box_h[4:0];
            o_result.advance      = adv[4:0];
        end
    end

endmodule

// ----- design/glyph_cell_bounding_box.sv -----
// Glyph cell bounding box: per-cell opaque extent of a streamed font atlas.
// Throughput: one pixel transaction per cycle while o_stall is low.
// The descriptor is registered and appears in the cycle after the cell's last pixel is taken.
// A descriptor held by an output stall stalls the pixel stream until it is taken.
// Reset (synchronous, active low): cell size 8x8, counters, box valid, index and output valid cleared.
module glyph_cell_bounding_box import gcbb_pkg::*; #(
    parameter int MAX_CELL   = 16,
    parameter int MAX_GLYPHS = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    // pixel stream
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [7:0]        i_alpha,
    input  logic              i_restart,
    // glyph descriptor stream
    output logic              o_valid,
    input  logic              i_stall,
    output logic [7:0]        o_glyph_index,
    output logic              o_is_empty,
    output logic [3:0]        o_bearing_x,
    output logic [3:0]        o_bearing_y,
    output logic [4:0]        o_glyph_width,
    output logic [4:0]        o_glyph_height,
    output logic [4:0]        o_advance
);

    localparam int CW = $clog2(MAX_CELL + 1);
    localparam int IW = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;

    logic [4:0]    r_cfg_w;
    logic [4:0]    r_cfg_h;
    logic [CW-1:0] r_col;
    logic [CW-1:0] r_row;
    logic [IW-1:0] r_cell_count;
    logic          r_box_valid;
    logic [CW-1:0] r_min_x;
    logic [CW-1:0] r_min_y;
    logic [CW-1:0] r_max_x;
    logic [CW-1:0] r_max_y;
    logic          r_out_valid;
    t_glyph_result r_out;

    logic [CW-1:0] w_eff;
    logic [CW-1:0] h_eff;
    logic          cfg_wr;
    logic          accept;
    logic [CW-1:0] col_b;
    logic [CW-1:0] row_b;
    logic [IW-1:0] count_b;
    logic          valid_b;
    logic          opaque;
    logic [CW-1:0] n_min_x;
    logic [CW-1:0] n_min_y;
    logic [CW-1:0] n_max_x;
    logic [CW-1:0] n_max_y;
    logic          n_box_valid;
    logic          col_last;
    logic          row_last;
    logic          finish;
    logic [IW-1:0] n_cell_count;
    t_glyph_result n_out;

    // Clamp the programmed cell size to 1..MAX_CELL
    always_comb begin
        if (r_cfg_w == '0) begin
            w_eff = CW'(1);
        end else if (32'(r_cfg_w) > 32'(MAX_CELL)) begin
            w_eff = CW'(MAX_CELL);
        end else begin
            w_eff = CW'(r_cfg_w);
        end
        if (r_cfg_h == '0) begin
            h_eff = CW'(1);
        end else if (32'(r_cfg_h) > 32'(MAX_CELL)) begin
            h_eff = CW'(MAX_CELL);
        end else begin
            h_eff = CW'(r_cfg_h);
        end
    end

    // Register access
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        case (paddr[2])
            REG_CELL_WIDTH:  prdata = 32'(r_cfg_w);
            REG_CELL_HEIGHT: prdata = 32'(r_cfg_h);
            default:         prdata = '0;
        endcase
    end

    // Handshake: stall only when a finished descriptor is still waiting
    assign o_stall = r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    // Restart drops the cell in progress and rewinds the index
    assign col_b   = i_restart ? '0 : r_col;
    assign row_b   = i_restart ? '0 : r_row;
    assign count_b = i_restart ? '0 : r_cell_count;
    assign valid_b = i_restart ? 1'b0 : r_box_valid;
    assign opaque  = (i_alpha != '0);

    // Grow the box with an opaque pixel
    always_comb begin
        n_min_x = r_min_x;
        n_min_y = r_min_y;
        n_max_x = r_max_x;
        n_max_y = r_max_y;
        if (opaque) begin
            if (!valid_b || col_b < r_min_x) n_min_x = col_b;
            if (!valid_b || row_b < r_min_y) n_min_y = row_b;
            if (!valid_b || col_b > r_max_x) n_max_x = col_b;
            if (!valid_b || row_b > r_max_y) n_max_y = row_b;
        end
    end

    assign n_box_valid  = valid_b || opaque;
    assign col_last     = (col_b == w_eff - CW'(1));
    assign row_last     = (row_b == h_eff - CW'(1));
    assign finish       = col_last && row_last;
    assign n_cell_count = (count_b == IW'(MAX_GLYPHS - 1)) ? '0 : count_b + IW'(1);

    gcbb_result #(
        .CW (CW),
        .IW (IW)
    ) u_result (
        .i_cell_w    (w_eff),
        .i_cell_h    (h_eff),
        .i_min_x     (n_min_x),
        .i_min_y     (n_min_y),
        .i_max_x     (n_max_x),
        .i_max_y     (n_max_y),
        .i_box_valid (n_box_valid),
        .i_index     (count_b),
        .o_result    (n_out)
    );

    // Control state: configuration, raster position, index, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w      <= CFG_SIZE_RESET;
            r_cfg_h      <= CFG_SIZE_RESET;
            r_col        <= '0;
            r_row        <= '0;
            r_cell_count <= '0;
            r_box_valid  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (cfg_wr) begin
                // a write abandons the cell in progress, the index is kept
                if (paddr[2] == REG_CELL_HEIGHT) begin
                    r_cfg_h <= pwdata[4:0];
                end else begin
                    r_cfg_w <= pwdata[4:0];
                end
                r_col       <= '0;
                r_row       <= '0;
                r_box_valid <= 1'b0;
            end else if (accept) begin
                if (!col_last) begin
                    r_col        <= col_b + CW'(1);
                    r_row        <= row_b;
                    r_cell_count <= count_b;
                    r_box_valid  <= n_box_valid;
                end else if (!row_last) begin
                    r_col        <= '0;
                    r_row        <= row_b + CW'(1);
                    r_cell_count <= count_b;
                    r_box_valid  <= n_box_valid;
                end else begin
                    r_col        <= '0;
                    r_row        <= '0;
                    r_cell_count <= n_cell_count;
                    r_box_valid  <= 1'b0;
                end
            end
            if (accept && finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload: box extent and descriptor register
    always_ff @(posedge i_clk) begin
        if (accept && !cfg_wr) begin
            r_min_x <= n_min_x;
            r_min_y <= n_min_y;
            r_max_x <= n_max_x;
            r_max_y <= n_max_y;
        end
        if (accept && finish) begin
            r_out <= n_out;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_glyph_index  = r_out.glyph_index;
    assign o_is_empty     = r_out.is_empty;
    assign o_bearing_x    = r_out.bearing_x;
    assign o_bearing_y    = r_out.bearing_y;
    assign o_glyph_width  = r_out.glyph_width;
    assign o_glyph_height = r_out.glyph_height;
    assign o_advance      = r_out.advance;

`ifndef SYNTHESIS
    // Raster position stays inside the cell
    a_pos_in_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col < w_eff) && (r_row < h_eff))
        else $error("raster position outside cell");

    // A tracked box is never inverted
    a_box_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_box_valid |-> (r_max_x >= r_min_x) && (r_max_y >= r_min_y))
        else $error("bounding box inverted");

    // The last pixel of a cell always yields a descriptor next cycle
    a_finish_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && finish && !cfg_wr) |=> o_valid)
        else $error("finished cell produced no descriptor");

    // Empty cells advance by zero or by the fixed space glyph advance
    a_empty_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_empty) |-> (o_advance == 5'd0 || o_advance == SPACE_ADVANCE))
        else $error("bad advance on empty cell");
`endif

endmodule
